### rtl/core/dstwr_pkg.sv
// Package for the double-sided two-way ranging distance core.
// Holds field widths, register reset value and default sizes; no dependencies.
package dstwr_pkg;

  localparam int STAMP_BITS_DEF = 40;
  localparam int SCALE_W        = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd307388;
  localparam int DIST_W         = 32;
  localparam int FLIGHT_W       = 48;
  localparam int QUEUE_DEPTH    = 2;

endpackage

### rtl/core/dstwr_if.sv
// Stream interfaces for the ranging core: timestamp input and distance result.
// Depends on dstwr_pkg for the result field widths.
interface dstwr_in_if #(parameter int W = 40);
  logic         valid;
  logic         ready;
  logic [W-1:0] poll_sent;
  logic [W-1:0] poll_received;
  logic [W-1:0] reply_sent;
  logic [W-1:0] reply_received;
  logic [W-1:0] final_sent;
  logic [W-1:0] final_received;

  modport source (output valid, poll_sent, poll_received, reply_sent, reply_received,
                  final_sent, final_received, input ready);
  modport sink (input valid, poll_sent, poll_received, reply_sent, reply_received,
                final_sent, final_received, output ready);
endinterface

interface dstwr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [dstwr_pkg::DIST_W-1:0]         distance_mm;
  logic signed [dstwr_pkg::FLIGHT_W-1:0] flight_ticks;
  logic                                 zero_denominator;

  modport source (output valid, distance_mm, flight_ticks, zero_denominator, input ready);
  modport sink (input valid, distance_mm, flight_ticks, zero_denominator, output ready);
endinterface

### rtl/core/dstwr_front.sv
// Front end: accepts timestamp sets, forms the four wrapped intervals and the denominator.
// Depends on dstwr_pkg and dstwr_in_if.
module dstwr_front #(
  parameter int S = dstwr_pkg::STAMP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  dstwr_in_if.sink         in_ch,
  output logic             item_valid,
  input  logic             item_ready,
  output logic [5*S+2:0]   item
);
  import dstwr_pkg::*;

  logic [S-1:0] ra, rb, da, db;
  logic [S+1:0] den;

  assign in_ch.ready = !item_valid || item_ready;

  always_comb begin
    ra  = in_ch.reply_received - in_ch.poll_sent;
    rb  = in_ch.final_received - in_ch.reply_sent;
    da  = in_ch.final_sent - in_ch.reply_received;
    db  = in_ch.reply_sent - in_ch.poll_received;
    den = (S+2)'(ra) + (S+2)'(rb) + (S+2)'(da) + (S+2)'(db);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item <= {den == '0, den, ra, rb, da, db};
    end
  end

endmodule

### rtl/core/dstwr_fifo.sv
// Short queue that decouples the front end from the arithmetic back end.
// Depends on dstwr_pkg for the default depth.
module dstwr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = dstwr_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import dstwr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [0:DEPTH-1];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/dstwr_back.sv
// Back end: split multipliers, pipelined restoring divider, scaling and saturation.
// Depends on dstwr_pkg and dstwr_out_if.
module dstwr_back #(
  parameter int S = dstwr_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [5*S+2:0]                 in_item,
  input  logic [dstwr_pkg::SCALE_W-1:0]  scale,
  dstwr_out_if.source                    out_ch
);
  import dstwr_pkg::*;

  localparam int H  = (S + 1) / 2;
  localparam int HH = S - H;
  localparam int DW = S + 2;

  logic adv;
  assign adv      = !out_ch.valid || out_ch.ready;
  assign in_ready = adv;

  logic [S-1:0]  ra, rb, da, db;
  logic [DW-1:0] in_den;
  assign {ra, rb, da, db} = in_item[4*S-1:0];
  assign in_den = in_item[5*S+1:4*S];

  // stage A: partial products
  logic              a_valid, a_zero;
  logic [DW-1:0]     a_den;
  logic [2*H-1:0]    a1_00, a2_00;
  logic [S-1:0]      a1_01, a1_10, a2_01, a2_10;
  logic [2*HH-1:0]   a1_11, a2_11;

  // stage B: full products
  logic              b_valid, b_zero;
  logic [DW-1:0]     b_den;
  logic [2*S-1:0]    b_p1, b_p2;

  // divider stages
  logic              vd   [0:S];
  logic              zd   [0:S];
  logic              nd   [0:S];
  logic [DW-1:0]     dd   [0:S];
  logic [DW-1:0]     rem  [0:S];
  logic [S-1:0]      low  [0:S];
  logic [S-1:0]      qd   [0:S];
  logic [DW:0]       trial [0:S-1];
  logic              ge   [0:S-1];

  // stage E: scaling partials and flight
  logic                  e_valid, e_zero, e_neg, e_big, e_scale_zero;
  logic [47:0]           e_m_lo, e_m_hi;
  logic [FLIGHT_W-1:0]   e_flight;

  logic [64:0]           qx;
  logic [47:0]           q48;
  logic [FLIGHT_W-1:0]   flight_next;
  logic [71:0]           prod;
  logic [55:0]           scaled;
  logic [DIST_W-1:0]     dist_next;

  always_comb begin
    for (int k = 0; k < S; k++) begin
      trial[k] = {rem[k], low[k][S-1]};
      ge[k]    = trial[k] >= (DW+1)'(dd[k]);
    end
  end

  always_comb begin
    qx  = 65'(qd[S]);
    q48 = qx[47:0];
    if (nd[S]) begin
      flight_next = (qx > 65'h8000_0000_0000) ? 48'h8000_0000_0000 : 48'(65'd0 - qx);
    end else begin
      flight_next = (qx > 65'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : qx[47:0];
    end
  end

  always_comb begin
    prod   = (72'(e_m_hi) << 24) + 72'(e_m_lo);
    scaled = prod[71:16];
    if (e_zero || e_neg || e_scale_zero) begin
      dist_next = '0;
    end else if (e_big || scaled[55:32] != '0) begin
      dist_next = '1;
    end else begin
      dist_next = scaled[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      e_valid      <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int k = 0; k <= S; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (adv) begin
      a_valid      <= in_valid;
      b_valid      <= a_valid;
      vd[0]        <= b_valid;
      for (int k = 0; k < S; k++) begin
        vd[k+1] <= vd[k];
      end
      e_valid      <= vd[S];
      out_ch.valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_zero <= in_item[5*S+2];
      a_den  <= in_den;
      a1_00  <= (2*H)'(ra[H-1:0]) * (2*H)'(rb[H-1:0]);
      a1_01  <= S'(ra[H-1:0]) * S'(rb[S-1:H]);
      a1_10  <= S'(ra[S-1:H]) * S'(rb[H-1:0]);
      a1_11  <= (2*HH)'(ra[S-1:H]) * (2*HH)'(rb[S-1:H]);
      a2_00  <= (2*H)'(da[H-1:0]) * (2*H)'(db[H-1:0]);
      a2_01  <= S'(da[H-1:0]) * S'(db[S-1:H]);
      a2_10  <= S'(da[S-1:H]) * S'(db[H-1:0]);
      a2_11  <= (2*HH)'(da[S-1:H]) * (2*HH)'(db[S-1:H]);

      b_zero <= a_zero;
      b_den  <= a_den;
      b_p1   <= (2*S)'(a1_00) + ((2*S)'(a1_01) << H) + ((2*S)'(a1_10) << H)
                + ((2*S)'(a1_11) << (2*H));
      b_p2   <= (2*S)'(a2_00) + ((2*S)'(a2_01) << H) + ((2*S)'(a2_10) << H)
                + ((2*S)'(a2_11) << (2*H));

      // sign and magnitude; quotient fits in S bits so the upper half starts below den
      zd[0]  <= b_zero;
      dd[0]  <= b_den;
      nd[0]  <= b_p1 < b_p2;
      if (b_p1 < b_p2) begin
        rem[0] <= DW'(b_p2[2*S-1:S] - b_p1[2*S-1:S] - S'(b_p2[S-1:0] < b_p1[S-1:0]));
        low[0] <= b_p2[S-1:0] - b_p1[S-1:0];
      end else begin
        rem[0] <= DW'(b_p1[2*S-1:S] - b_p2[2*S-1:S] - S'(b_p1[S-1:0] < b_p2[S-1:0]));
        low[0] <= b_p1[S-1:0] - b_p2[S-1:0];
      end
      qd[0]  <= '0;

      for (int k = 0; k < S; k++) begin
        zd[k+1]  <= zd[k];
        dd[k+1]  <= dd[k];
        nd[k+1]  <= nd[k];
        low[k+1] <= low[k] << 1;
        qd[k+1]  <= {qd[k][S-2:0], ge[k]};
        rem[k+1] <= ge[k] ? DW'(trial[k] - (DW+1)'(dd[k])) : DW'(trial[k]);
      end

      e_zero       <= zd[S];
      e_neg        <= nd[S];
      e_big        <= qx[64:48] != '0;
      e_scale_zero <= scale == '0;
      e_flight     <= zd[S] ? '0 : flight_next;
      e_m_lo       <= 48'(q48[23:0]) * 48'(scale);
      e_m_hi       <= 48'(q48[47:24]) * 48'(scale);

      out_ch.distance_mm      <= dist_next;
      out_ch.flight_ticks     <= e_flight;
      out_ch.zero_denominator <= e_zero;
    end
  end

endmodule

### rtl/core/double_sided_twr_distance_core.sv
// Double-sided two-way ranging distance core. Takes one set of six timestamps per cycle
// and returns distance, time of flight and a zero-denominator flag, one result per cycle,
// both while the output is not stalled. The input register loads on the transfer edge,
// then come the queue, a two-stage split multiplier, a sign stage, one quotient bit per
// divider stage, a scaling stage and the output register.
// The scale factor is read by items in flight, so write it only while no item is in the
// pipeline.
// Depends on dstwr_pkg, dstwr_if, dstwr_front, dstwr_fifo and dstwr_back.
module double_sided_twr_distance_core #(
  parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dstwr_in_if.sink                      in_ch,
  dstwr_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic [dstwr_pkg::SCALE_W-1:0] cfg_wdata
);
  import dstwr_pkg::*;

  localparam int IW = 5 * STAMP_BITS + 3;

  logic [SCALE_W-1:0] scale;
  logic               f_valid, f_ready, q_valid, q_ready;
  logic [IW-1:0]      f_item, q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_wdata;
    end
  end

  dstwr_front #(.S(STAMP_BITS)) u_front (
    .clk, .rst, .in_ch,
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  dstwr_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_item),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_item)
  );

  dstwr_back #(.S(STAMP_BITS)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .scale, .out_ch
  );

endmodule

### verif/double_sided_twr_distance_core_tb.sv
// Testbench for double_sided_twr_distance_core: directed table plus random ranging exchanges,
// checked field by field against an in-bench predictor across several scale settings.
// Depends on dstwr_pkg, dstwr_if and the core RTL.
module double_sided_twr_distance_core_tb;
  import dstwr_pkg::*;

  localparam int STAMP_W    = STAMP_BITS_DEF;
  localparam int LATENCY    = STAMP_W + 8;
  localparam int STALL_MAX  = 4000;
  localparam int RANDOM_PER = 250;

  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    stamp_t poll_sent;
    stamp_t poll_received;
    stamp_t reply_sent;
    stamp_t reply_received;
    stamp_t final_sent;
    stamp_t final_received;
  } exchange_t;

  typedef struct packed {
    logic [DIST_W-1:0]          distance_mm;
    logic signed [FLIGHT_W-1:0] flight_ticks;
    logic                       zero_denominator;
  } range_t;

  typedef struct packed {
    exchange_t ex;
    logic      typed;
    range_t    res;
  } table_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  dstwr_in_if #(STAMP_W) in_ch();
  dstwr_out_if           out_ch();

  double_sided_twr_distance_core #(.STAMP_BITS(STAMP_W)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  range_t             expected_ranges[$];
  logic [SCALE_W-1:0] scale_q16;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 quiet_cycles;
  bit                 failed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact time of flight, then scale, clamp and saturate.
  function automatic range_t predict_range(exchange_t e, logic [SCALE_W-1:0] scale);
    stamp_t       ra, rb, da, db;
    logic [127:0] den, p1, p2, mag, q, d;
    logic         neg;
    range_t       r;
    ra = e.reply_received - e.poll_sent;
    rb = e.final_received - e.reply_sent;
    da = e.final_sent - e.reply_received;
    db = e.reply_sent - e.poll_received;
    den = 128'(ra) + 128'(rb) + 128'(da) + 128'(db);
    r = '0;
    if (den == 0) begin
      r.zero_denominator = 1'b1;
      return r;
    end
    p1 = 128'(ra) * 128'(rb);
    p2 = 128'(da) * 128'(db);
    neg = p1 < p2;
    mag = neg ? p2 - p1 : p1 - p2;
    q = mag / den;
    if (neg)
      r.flight_ticks = (q > 128'h8000_0000_0000) ? 48'h8000_0000_0000 : -q[47:0];
    else
      r.flight_ticks = (q > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q[47:0];
    if (neg || scale == 0) begin
      r.distance_mm = '0;
    end else if (q >= (128'd1 << 48)) begin
      r.distance_mm = '1;
    end else begin
      d = (q >> 16) * scale + (((q & 128'hFFFF) * scale) >> 16);
      r.distance_mm = (d > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    end
    return r;
  endfunction

  function automatic exchange_t make_exchange(stamp_t t0, stamp_t t1, stamp_t ra, stamp_t db,
                                              stamp_t da, stamp_t rb);
    exchange_t e;
    e.poll_sent      = t0;
    e.reply_received = t0 + ra;
    e.final_sent     = e.reply_received + da;
    e.poll_received  = t1;
    e.reply_sent     = t1 + db;
    e.final_received = e.reply_sent + rb;
    return e;
  endfunction

  function automatic stamp_t rand_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  function automatic exchange_t random_exchange();
    int     pick;
    stamp_t db, da, tof2;
    pick = $urandom_range(99);
    if (pick < 15) begin
      return {rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(),
              rand_stamp()};
    end else if (pick < 25) begin
      return make_exchange(rand_stamp(), rand_stamp(), $urandom_range(3), $urandom_range(3),
                           $urandom_range(3), $urandom_range(3));
    end
    db = ($urandom_range(9) == 0) ? rand_stamp() : stamp_t'($urandom_range(32'h7FFF_FFFF));
    da = ($urandom_range(9) == 0) ? rand_stamp() : stamp_t'($urandom_range(32'h7FFF_FFFF));
    tof2 = 2 * $urandom_range(5000);
    return make_exchange(rand_stamp(), rand_stamp(), db + tof2 + $urandom_range(6) - 3, db,
                         da, da + tof2 + $urandom_range(6) - 3);
  endfunction

  // Hold valid until the transfer; idle beforehand at the configured rate.
  task automatic send_exchange(exchange_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.poll_sent      <= e.poll_sent;
    in_ch.poll_received  <= e.poll_received;
    in_ch.reply_sent     <= e.reply_sent;
    in_ch.reply_received <= e.reply_received;
    in_ch.final_sent     <= e.final_sent;
    in_ch.final_received <= e.final_received;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    scale_q16 = v;
  endtask

  // Predict on the input transfer, using the scale in force then.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      expected_ranges.push_back(predict_range({in_ch.poll_sent, in_ch.poll_received,
          in_ch.reply_sent, in_ch.reply_received, in_ch.final_sent, in_ch.final_received},
          scale_q16));
  end

  always @(posedge clk) begin
    range_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected result dist=%0d flight=%0d zden=%0b", $time,
                 out_ch.distance_mm, out_ch.flight_ticks, out_ch.zero_denominator);
        failed = 1'b1;
      end else begin
        want = expected_ranges.pop_front();
        if (out_ch.distance_mm !== want.distance_mm) begin
          $display("%0t: distance_mm expected %0d got %0d", $time, want.distance_mm,
                   out_ch.distance_mm);
          failed = 1'b1;
        end
        if (out_ch.flight_ticks !== want.flight_ticks) begin
          $display("%0t: flight_ticks expected %0d got %0d", $time, want.flight_ticks,
                   out_ch.flight_ticks);
          failed = 1'b1;
        end
        if (out_ch.zero_denominator !== want.zero_denominator) begin
          $display("%0t: zero_denominator expected %0b got %0b", $time,
                   want.zero_denominator, out_ch.zero_denominator);
          failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("double_sided_twr_distance_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  localparam stamp_t SMAX = '1;
  localparam range_t ZDEN = '{distance_mm: '0, flight_ticks: '0, zero_denominator: 1'b1};

  table_row_t stimulus_table[] = '{
    '{'{0, 0, 0, 0, 0, 0}, 1'b1, ZDEN},
    '{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX}, 1'b1, ZDEN},
    '{'{40'h12_3456_789A, 40'h55_0000_0000, 40'h55_0000_0000, 40'h12_3456_789A,
        40'h12_3456_789A, 40'h55_0000_0000}, 1'b1, ZDEN},
    '{make_exchange(1000, 5000, 200_200, 200_000, 300_000, 300_200), 1'b0, '0},
    '{make_exchange(SMAX - 50, SMAX - 10, 200_200, 200_000, 300_000, 300_200), 1'b0, '0},
    '{make_exchange(0, 0, 100, 300_000, 400_000, 100), 1'b0, '0},
    '{make_exchange(0, 0, SMAX, 0, 0, SMAX), 1'b0, '0},
    '{make_exchange(SMAX, 0, SMAX, 0, 0, SMAX), 1'b0, '0},
    '{make_exchange(0, SMAX, 0, SMAX, SMAX, 0), 1'b0, '0},
    '{make_exchange(0, 0, SMAX, SMAX, SMAX, SMAX), 1'b0, '0},
    '{make_exchange(0, 0, 1, 0, 0, 0), 1'b0, '0},
    '{make_exchange(0, 0, 0, 1, 1, 0), 1'b0, '0},
    '{make_exchange(40'hAA_AAAA_AAAA, 40'h55_5555_5555, 1_000_040, 1_000_000, 2_000_000,
                    2_000_040), 1'b0, '0},
    '{'{SMAX, 0, SMAX, 0, SMAX, 0}, 1'b0, '0},
    '{'{0, SMAX, 0, SMAX, 0, SMAX}, 1'b0, '0},
    '{make_exchange(0, 0, 40'h1_0000_0000, 40'h8000, 40'h8000, 40'h1_0000_0000), 1'b0, '0}
  };

  initial begin
    logic [SCALE_W-1:0] phase_scale[4];
    int                 phase_idle[4];
    int                 phase_stall[4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.poll_sent = '0;
    in_ch.poll_received = '0;
    in_ch.reply_sent = '0;
    in_ch.reply_received = '0;
    in_ch.final_sent = '0;
    in_ch.final_received = '0;
    out_ch.ready = 1'b0;
    scale_q16 = SCALE_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    failed = 1'b0;
    phase_scale = '{SCALE_RESET, '0, '1, SCALE_W'($urandom)};
    phase_idle  = '{0, 70, 0, 34};
    phase_stall = '{0, 0, 70, 34};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stimulus_table[i]) begin
      send_exchange(stimulus_table[i].ex);
      if (stimulus_table[i].typed) begin
        // The typed row overrides the prediction pushed on its transfer.
        expected_ranges[expected_ranges.size() - 1] = stimulus_table[i].res;
      end
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      write_scale(phase_scale[p]);
      for (int n = 0; n < RANDOM_PER; n++) begin
        // Run a stretch with no idling in the middle of each throttled phase.
        if (n == RANDOM_PER / 2) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end else if (n == RANDOM_PER / 2 + 30) begin
          send_idle_pct = phase_idle[p];
          recv_stall_pct = phase_stall[p];
        end
        send_exchange(random_exchange());
      end
    end

    drain();
    if (!failed)
      $display("double_sided_twr_distance_core test passed");
    else
      $display("double_sided_twr_distance_core test failed");
    $finish;
  end

endmodule
